// ===== design/xsp_pkg.sv =====
// shared types and constants of the xoshiro256++ generator with splitmix64 seeding
`timescale 1ns / 1ps
`default_nettype none
package xsp_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned FracW = 53;
	localparam int unsigned HalfW = 32;

	localparam logic [WordW-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WordW-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [WordW-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

	localparam logic REQ_RESEED = 1'b0;
	localparam logic REQ_DRAW   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LL_A,
		ST_MUL_HL_A,
		ST_MUL_LH_A,
		ST_MIX_B,
		ST_MUL_LL_B,
		ST_MUL_HL_B,
		ST_MUL_LH_B,
		ST_STORE,
		ST_ADVANCE
	} xsp_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SEED,
		OP_ADVANCE,
		OP_DRAW,
		OP_MUL_LL,
		OP_MUL_HL,
		OP_MUL_LH,
		OP_MIX_B,
		OP_STORE
	} xsp_op_t;

	typedef struct packed {
		xsp_op_t op;
		logic    use_b;
	} xsp_cmd_t;

	typedef struct packed {
		logic out_free;
	} xsp_status_t;

endpackage
`default_nettype wire

// ===== design/xsp_req_if.sv =====
// request channel: request type and seed
`timescale 1ns / 1ps
`default_nettype none
interface xsp_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] seed_value;

	modport source (output valid, output req_type, output seed_value, input ready);
	modport sink (input valid, input req_type, input seed_value, output ready);
endinterface
`default_nettype wire

// ===== design/xsp_rsp_if.sv =====
// result channel: random word and uniform fraction
`timescale 1ns / 1ps
`default_nettype none
interface xsp_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_word;
	logic [52:0] uniform_fraction;

	modport source (output valid, output random_word, output uniform_fraction, input ready);
	modport sink (input valid, input random_word, input uniform_fraction, output ready);
endinterface
`default_nettype wire

// ===== design/xsp_ctrl.sv =====
// controller: request acceptance and splitmix64 reseed sequencing
`timescale 1ns / 1ps
`default_nettype none
module xsp_ctrl
	import xsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_req_type,
	output      logic        in_ready,
	input  wire xsp_status_t status,
	output      xsp_cmd_t    cmd
);

	xsp_state_t state_q, state_d;
	logic [1:0] round_q, round_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= 2'd0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		round_d   = round_q;
		in_ready  = 1'b0;
		cmd.op    = OP_NONE;
		cmd.use_b = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					if (in_req_type == REQ_DRAW) begin
						cmd.op = OP_DRAW;
					end else begin
						cmd.op  = OP_SEED;
						round_d = 2'd0;
						state_d = ST_MUL_LL_A;
					end
				end
			end
			ST_MUL_LL_A: begin
				cmd.op  = OP_MUL_LL;
				state_d = ST_MUL_HL_A;
			end
			ST_MUL_HL_A: begin
				cmd.op  = OP_MUL_HL;
				state_d = ST_MUL_LH_A;
			end
			ST_MUL_LH_A: begin
				cmd.op  = OP_MUL_LH;
				state_d = ST_MIX_B;
			end
			ST_MIX_B: begin
				cmd.op  = OP_MIX_B;
				state_d = ST_MUL_LL_B;
			end
			ST_MUL_LL_B: begin
				cmd.op    = OP_MUL_LL;
				cmd.use_b = 1'b1;
				state_d   = ST_MUL_HL_B;
			end
			ST_MUL_HL_B: begin
				cmd.op    = OP_MUL_HL;
				cmd.use_b = 1'b1;
				state_d   = ST_MUL_LH_B;
			end
			ST_MUL_LH_B: begin
				cmd.op    = OP_MUL_LH;
				cmd.use_b = 1'b1;
				state_d   = ST_STORE;
			end
			ST_STORE: begin
				cmd.op = OP_STORE;
				if (round_q == 2'd3) begin
					round_d = 2'd0;
					state_d = ST_IDLE;
				end else begin
					round_d = round_q + 2'd1;
					state_d = ST_ADVANCE;
				end
			end
			ST_ADVANCE: begin
				cmd.op  = OP_ADVANCE;
				state_d = ST_MUL_LL_A;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/xsp_datapath.sv =====
// datapath: generator state, splitmix64 mixer on a shared 32x32 multiplier, output register
`timescale 1ns / 1ps
`default_nettype none
module xsp_datapath
	import xsp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire xsp_cmd_t          cmd,
	output      xsp_status_t       status,
	input  wire logic [WordW-1:0]  seed_value,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [WordW-1:0]  random_word,
	output      logic [FracW-1:0]  uniform_fraction
);

	logic [WordW-1:0] s0_q, s1_q, s2_q, s3_q;
	logic [WordW-1:0] counter_q, z_q, acc_q;
	logic             out_valid_q;
	logic [WordW-1:0] word_q;

	logic [WordW-1:0] ctr_next, ctr_mix;
	logic [WordW-1:0] mul_const;
	logic [HalfW-1:0] mul_a, mul_b;
	logic [WordW-1:0] mul_p;
	logic [WordW-1:0] mix_b, mix_out;

	logic [WordW-1:0] draw_sum, draw_word;
	logic [WordW-1:0] t2, t3, t1, t0, n2, n3;

	// splitmix64 counter step and first xor-shift
	assign ctr_next = ((cmd.op == OP_SEED) ? seed_value : counter_q) + GOLDEN_STEP;
	assign ctr_mix  = ctr_next ^ (ctr_next >> 30);
	assign mix_b    = acc_q ^ (acc_q >> 27);
	assign mix_out  = acc_q ^ (acc_q >> 31);

	// 64x64 low product from three 32x32 partial products
	assign mul_const = cmd.use_b ? MIX_MUL_B : MIX_MUL_A;
	always_comb begin
		mul_a = z_q[HalfW-1:0];
		mul_b = mul_const[HalfW-1:0];
		if (cmd.op == OP_MUL_HL) begin
			mul_a = z_q[WordW-1:HalfW];
		end
		if (cmd.op == OP_MUL_LH) begin
			mul_b = mul_const[WordW-1:HalfW];
		end
	end
	assign mul_p = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};

	// xoshiro256++ output and state update
	assign draw_sum  = s0_q + s3_q;
	assign draw_word = {draw_sum[40:0], draw_sum[63:41]} + s0_q;
	assign t2        = s2_q ^ s0_q;
	assign t3        = s3_q ^ s1_q;
	assign t1        = s1_q ^ t2;
	assign t0        = s0_q ^ t3;
	assign n2        = t2 ^ {s1_q[46:0], 17'd0};
	assign n3        = {t3[18:0], t3[63:19]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q        <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			s3_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_DRAW: begin
					s0_q <= t0;
					s1_q <= t1;
					s2_q <= n2;
					s3_q <= n3;
				end
				OP_STORE: begin
					// first word out of the mixer ends up in s0 after four rounds
					s0_q <= s1_q;
					s1_q <= s2_q;
					s2_q <= s3_q;
					s3_q <= mix_out;
				end
				OP_NONE, OP_SEED, OP_ADVANCE, OP_MUL_LL, OP_MUL_HL, OP_MUL_LH,
				OP_MIX_B: begin
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_DRAW) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SEED, OP_ADVANCE: begin
				counter_q <= ctr_next;
				z_q       <= ctr_mix;
			end
			OP_MUL_LL: begin
				acc_q <= mul_p;
			end
			OP_MUL_HL, OP_MUL_LH: begin
				acc_q <= acc_q + {mul_p[HalfW-1:0], {HalfW{1'b0}}};
			end
			OP_MIX_B: begin
				z_q <= mix_b;
			end
			OP_DRAW: begin
				word_q <= draw_word;
			end
			OP_NONE, OP_STORE: begin
			end
			default: begin
			end
		endcase
	end

	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign random_word      = word_q;
	assign uniform_fraction = word_q[WordW-1:WordW-FracW];

endmodule
`default_nettype wire

// ===== design/xoshiro256pp_splitmix_prng.sv =====
// draw: result registered in the output register in the cycle after the transfer, one draw per cycle
// while the result side keeps up; a full output register that is not taken holds requests
// reseed: four splitmix64 rounds on the shared 32x32 multiplier after the transfer, with a
// counter step between rounds; no result, no request taken meanwhile
// reset: asynchronous, clears the generator state to zero and empties the output register
`timescale 1ns / 1ps
`default_nettype none
module xoshiro256pp_splitmix_prng
	import xsp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	xsp_req_if.sink   req,
	xsp_rsp_if.source rsp
);

	xsp_cmd_t    cmd;
	xsp_status_t status;
	logic        in_ready;

	xsp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (in_ready),
		.status      (status),
		.cmd         (cmd)
	);

	xsp_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.seed_value       (req.seed_value),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.random_word      (rsp.random_word),
		.uniform_fraction (rsp.uniform_fraction)
	);

	assign req.ready = in_ready;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench of the xoshiro256++ generator with splitmix64 seeding
`timescale 1ns / 1ps
module tb_top;
	import xsp_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned RandomReqs = 1200;
	localparam int unsigned LongHoldAt = 400;
	localparam int unsigned LongHoldLen = 120;
	localparam int unsigned TailCycles = 60;

	typedef struct {
		logic            kind;
		logic [WordW-1:0] seed;
		int unsigned     gap;
		bit              drain;
	} request_t;

	typedef struct {
		logic [WordW-1:0] word;
		logic [FracW-1:0] frac;
	} draw_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	xsp_req_if req_if ();
	xsp_rsp_if rsp_if ();

	xoshiro256pp_splitmix_prng uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #4 clk = ~clk;

	request_t         pending[$];
	draw_result_t     due_draws[$];
	logic [WordW-1:0] gen_state[4];
	int unsigned      total_reqs = 0;
	int unsigned      accepted_reqs = 0;
	int unsigned      draws_seen = 0;
	int unsigned      errors = 0;
	int unsigned      cycles = 0;

	function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] v,
			input int unsigned n);
		return (v << n) | (v >> (WordW - n));
	endfunction

	function automatic logic [WordW-1:0] splitmix_mix(input logic [WordW-1:0] ctr);
		logic [WordW-1:0] z;
		z = ctr;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	// model state update for one accepted request, queueing the draw it yields
	task automatic predict_request(input request_t r);
		logic [WordW-1:0] ctr;
		logic [WordW-1:0] word;
		logic [WordW-1:0] shifted;
		draw_result_t     res;
		if (r.kind == REQ_RESEED) begin
			ctr = r.seed;
			for (int i = 0; i < 4; i++) begin
				ctr = ctr + GOLDEN_STEP;
				gen_state[i] = splitmix_mix(ctr);
			end
		end else begin
			word = rotl64(gen_state[0] + gen_state[3], 23) + gen_state[0];
			shifted = gen_state[1] << 17;
			gen_state[2] = gen_state[2] ^ gen_state[0];
			gen_state[3] = gen_state[3] ^ gen_state[1];
			gen_state[1] = gen_state[1] ^ gen_state[2];
			gen_state[0] = gen_state[0] ^ gen_state[3];
			gen_state[2] = gen_state[2] ^ shifted;
			gen_state[3] = rotl64(gen_state[3], 45);
			res.word = word;
			res.frac = word[WordW-1:WordW-FracW];
			due_draws.push_back(res);
		end
	endtask

	task automatic add_req(input logic kind, input logic [WordW-1:0] seed,
			input int unsigned gap, input bit drain);
		request_t r;
		r.kind = kind;
		r.seed = seed;
		r.gap = gap;
		r.drain = drain;
		pending.push_back(r);
		total_reqs++;
	endtask

	// driver: one item on the request channel at a time
	request_t    cur_req;
	int unsigned wait_cnt = 0;

	always @(posedge clk) begin : drive_proc
		logic nxt_valid;
		logic launch;
		nxt_valid = req_if.valid;
		launch = 1'b0;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				predict_request(cur_req);
				accepted_reqs++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending.size() != 0) begin
				// a drain item waits until every queued draw has come back
				if (pending[0].drain && due_draws.size() != 0) begin
					wait_cnt = 0;
				end else if (wait_cnt < pending[0].gap) begin
					wait_cnt++;
				end else begin
					cur_req = pending.pop_front();
					wait_cnt = 0;
					nxt_valid = 1'b1;
					launch = 1'b1;
				end
			end
		end
		req_if.valid <= nxt_valid;
		if (launch) begin
			req_if.req_type <= cur_req.kind;
			req_if.seed_value <= cur_req.seed;
		end
	end

	// monitor: takes results with random back-pressure and checks them
	int unsigned stall_left = 0;

	always @(posedge clk) begin : monitor_proc
		logic         rdy;
		draw_result_t exp_res;
		rdy = 1'b0;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (due_draws.size() == 0) begin
					$display("%0t: unexpected result word %h fraction %h", $time,
						rsp_if.random_word, rsp_if.uniform_fraction);
					errors++;
				end else begin
					exp_res = due_draws.pop_front();
					if (rsp_if.random_word !== exp_res.word) begin
						$display("%0t: random_word expected %h actual %h", $time,
							exp_res.word, rsp_if.random_word);
						errors++;
					end
					if (rsp_if.uniform_fraction !== exp_res.frac) begin
						$display("%0t: uniform_fraction expected %h actual %h", $time,
							exp_res.frac, rsp_if.uniform_fraction);
						errors++;
					end
				end
				draws_seen++;
				if (draws_seen == LongHoldAt)
					stall_left = LongHoldLen;
				else if ((draws_seen / 60) % 5 == 3)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, 5);
			end
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				rdy = 1'b1;
			end
		end
		rsp_if.ready <= rdy;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic        kind;
		logic [WordW-1:0] seed;
		int unsigned gap;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_DRAW;
		req_if.seed_value = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < 4; i++)
			gen_state[i] = '0;

		// draws before any reseed stay at zero
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_DRAW, '1, 0, 0);
		add_req(REQ_DRAW, '0, 2, 0);
		add_req(REQ_RESEED, '0, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_DRAW, '1, 1, 0);
		add_req(REQ_RESEED, '1, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_RESEED, 64'h8000_0000_0000_0000, 3, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_RESEED, 64'h1, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_DRAW, '0, 4, 0);
		// counter wraps through zero on the first splitmix step
		add_req(REQ_RESEED, -GOLDEN_STEP, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_RESEED, ~GOLDEN_STEP, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		// back-to-back reseeds, only the second one counts
		add_req(REQ_RESEED, 64'hdead_beef_0123_4567, 0, 0);
		add_req(REQ_RESEED, 64'h7fff_ffff_ffff_ffff, 0, 0);
		add_req(REQ_DRAW, '0, 0, 0);
		add_req(REQ_DRAW, '0, 5, 1);

		for (int i = 0; i < RandomReqs; i++) begin
			kind = ($urandom_range(0, 99) < 6) ? REQ_RESEED : REQ_DRAW;
			case ($urandom_range(0, 9))
				0: seed = '1;
				1: seed = '0;
				default: seed = {$urandom, $urandom};
			endcase
			gap = ((i / 50) % 5 == 2) ? 0 : $urandom_range(0, 5);
			add_req(kind, seed, gap, (i == 600 || i == 1000));
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_reqs < total_reqs || due_draws.size() != 0)
			@(posedge clk);
		// a trailing reseed may still be running
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
